/* sv/usfp_pkg.sv */
// Package for the serial setting frame parser: byte codes, frame sizes,
// the front state type and the command passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package usfp_pkg;

    localparam int FRAME_BYTES = 19;
    // Bytes 1 .. FRAME_BYTES-2 carry settings; byte 0 is start, the last byte is end.
    localparam int DATA_BYTES  = FRAME_BYTES - 2;
    localparam int COUNT_W     = 5;
    localparam int CH_WORDS    = 4;
    localparam int CH_TOTAL    = 13;
    localparam int CH_W        = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] BYTE_CAPTURE = 8'h43;
    localparam logic [7:0] BYTE_START   = 8'h53;
    localparam logic [7:0] BYTE_END     = 8'h45;

    localparam logic [COUNT_W-1:0] COUNT_END  = COUNT_W'(FRAME_BYTES - 1);
    localparam logic [CH_W-1:0]    CH_LAST    = CH_W'(CH_TOTAL - 1);
    localparam logic [CH_W-1:0]    CH_WORDS_C = CH_W'(CH_WORDS);

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_SETTING = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_FRAME = 1'b1
    } front_state_t;

    typedef struct packed {
        logic                          is_run;
        logic [DATA_BYTES-1:0][7:0]    data;
    } usfp_cmd_t;

    typedef struct packed {
        logic       valid;
        usfp_cmd_t  cmd;
    } usfp_push_t;

endpackage

`default_nettype wire

/* sv/usfp_front.sv */
// Front part of the parser: accepts bytes, tracks the frame and collects data.
// Depends on usfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usfp_front
    import usfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_data,
    input  wire logic        q_full,
    output usfp_push_t       push
);

    front_state_t               state_reg, state_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [DATA_BYTES-1:0][7:0] data_reg, data_next;
    logic                       accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Next state and counter.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (accept)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rx_data == BYTE_START)
                    begin
                        state_next = ST_FRAME;
                        count_next = COUNT_W'(1);
                    end
                end
                ST_FRAME:
                begin
                    if (count_reg == COUNT_END)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                end
            endcase
        end
    end

    // Outputs: data shift and queue push.
    always_comb
    begin
        data_next       = data_reg;
        push.valid      = 1'b0;
        push.cmd.is_run = 1'b0;
        push.cmd.data   = data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                push.valid = accept && (rx_data == BYTE_CAPTURE);
            end
            ST_FRAME:
            begin
                if (count_reg == COUNT_END)
                begin
                    push.valid      = accept && (rx_data == BYTE_END);
                    push.cmd.is_run = 1'b1;
                end
                else if (accept)
                begin
                    data_next = {rx_data, data_reg[DATA_BYTES-1:1]};
                end
            end
            default:
            begin
                push.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

/* sv/usfp_queue.sv */
// Short command queue between the front and back parts of the parser.
// Depends on usfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usfp_queue
    import usfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire usfp_push_t push,
    output logic            full,
    output logic            q_valid,
    output usfp_cmd_t       q_cmd,
    input  wire logic       pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    usfp_cmd_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/usfp_back.sv */
// Back part of the parser: takes commands and emits result items.
// Depends on usfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usfp_back
    import usfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  wire usfp_cmd_t    q_cmd,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              kind,
    output logic [CH_W-1:0]   channel,
    output logic [15:0]       setting_value,
    output logic              last
);

    logic                       busy_reg, busy_next;
    logic [CH_W-1:0]            ch_reg, ch_next;
    logic [DATA_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       kind_reg, kind_next;
    logic [CH_W-1:0]            channel_reg, channel_next;
    logic [15:0]                value_reg, value_next;
    logic                       last_reg, last_next;
    logic                       advance;
    logic                       is_word;

    assign advance = !out_valid_reg || !out_stall;
    assign is_word = (ch_reg < CH_WORDS_C);
    assign pop     = !busy_reg && q_valid && (q_cmd.is_run || advance);

    always_comb
    begin
        busy_next      = busy_reg;
        ch_next        = ch_reg;
        bytes_next     = bytes_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        channel_next   = channel_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        if (busy_reg)
        begin
            if (advance)
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_SETTING;
                channel_next   = ch_reg;
                last_next      = (ch_reg == CH_LAST);
                if (is_word)
                begin
                    value_next = {bytes_reg[0], bytes_reg[1]};
                    bytes_next = bytes_reg >> 16;
                end
                else
                begin
                    value_next = {8'h00, bytes_reg[0]};
                    bytes_next = bytes_reg >> 8;
                end
                ch_next   = ch_reg + CH_W'(1);
                busy_next = (ch_reg != CH_LAST);
            end
        end
        else if (pop && q_cmd.is_run)
        begin
            busy_next  = 1'b1;
            ch_next    = '0;
            bytes_next = q_cmd.data;
            if (advance)
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_CAPTURE;
            channel_next   = '0;
            value_next     = '0;
            last_next      = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg   <= bytes_next;
        kind_reg    <= kind_next;
        channel_reg <= channel_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign channel       = channel_reg;
    assign setting_value = value_reg;
    assign last          = last_reg;

    // A run never counts past the last channel.
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (ch_reg <= CH_LAST))
        else $error("channel counter past last channel");

    // A capture item is always a lone, marked item with zero fields.
    a_capture_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_CAPTURE)) |->
        (last_reg && (channel_reg == '0) && (value_reg == '0)))
        else $error("malformed capture item");

    // Setting items are marked last exactly on the final channel.
    a_setting_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_SETTING)) |->
        (last_reg == (channel_reg == CH_LAST)))
        else $error("last mark on wrong channel");

    // No new command is taken while a run is still being emitted.
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !pop)
        else $error("command taken during a run");

endmodule

`default_nettype wire

/* sv/uart_setting_frame_parser_core.sv */
// Top level of the serial setting frame parser: front, command queue, back.
// Depends on usfp_pkg, usfp_front, usfp_queue and usfp_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_stall   rx_data[7:0]
// output    out_valid / out_stall kind, channel[3:0], setting_value[15:0], last
//
// Each received byte is taken by the front part, which follows the
// frame and shifts data bytes into a register line. A capture byte or a frame
// with a good end byte becomes one command in a two-entry queue. The back part
// turns a capture command into one item and a frame command into 13 items, one
// per cycle while the output is not stalled, after a load step; its channel
// counter ends the run. The input stalls only while the queue is full.
// Reset clears the frame state, the queue and the output valid flag; data
// registers are not reset.

module uart_setting_frame_parser_core
    import usfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   rx_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              kind,
    output logic [3:0]        channel,
    output logic [15:0]       setting_value,
    output logic              last
);

    usfp_push_t push;
    usfp_cmd_t  q_cmd;
    logic       q_full;
    logic       q_valid;
    logic       pop;

    // The front classifies bytes and builds frame commands.
    usfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_data  (rx_data),
        .q_full   (q_full),
        .push     (push)
    );

    // The queue lets a run drain while further bytes arrive.
    usfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop)
    );

    // The back emits result items through its output register.
    usfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .channel       (channel),
        .setting_value (setting_value),
        .last          (last)
    );

endmodule

`default_nettype wire
